@@ sv/q16_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q16 package
// Opcodes, status codes, widths and the command/status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package q16_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned OpWidth    = 3;
   localparam int unsigned StatWidth  = 2;
   localparam int unsigned DivBits    = 49;   // |a| << 17 is 49 bits
   localparam int unsigned CntWidth   = 6;

   localparam logic [OpWidth-1:0] OpAdd = 3'd0;
   localparam logic [OpWidth-1:0] OpSub = 3'd1;
   localparam logic [OpWidth-1:0] OpMul = 3'd2;
   localparam logic [OpWidth-1:0] OpDiv = 3'd3;
   localparam logic [OpWidth-1:0] OpRem = 3'd4;

   localparam logic [StatWidth-1:0] StOk   = 2'd0;
   localparam logic [StatWidth-1:0] StOvf  = 2'd1;
   localparam logic [StatWidth-1:0] StDiv0 = 2'd2;

   localparam logic [DataWidth-1:0] OvfCode = 32'h8000_0000;

   typedef struct packed {
      logic load;    // capture operands and set up the operation
      logic step;    // one division step / multiply stage
      logic finish;  // form the result
   } q16_cmd_type;

   typedef struct packed {
      logic iter_done;
      logic is_div;
   } q16_stat_type;

endpackage

@@ sv/q16_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q16 stream interface
// Valid/ready channels: a request with opcode and two operands, a response with result and status.
// ----------------------------------------------------------------------------
interface q16_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [q16_pkg::OpWidth-1:0]           req_type;
   logic signed [q16_pkg::DataWidth-1:0]  operand_a;
   logic signed [q16_pkg::DataWidth-1:0]  operand_b;
   modport source (output valid, req_type, operand_a, operand_b, input ready);
   modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface q16_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [q16_pkg::DataWidth-1:0]  result_value;
   logic [q16_pkg::StatWidth-1:0]         status;
   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

@@ sv/q16_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q16 controller
// Sequences load, division steps or multiply stages, and result hand-off.
// ----------------------------------------------------------------------------
module q16_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output q16_pkg::q16_cmd_type  cmd,
   input  q16_pkg::q16_stat_type stat
);

   typedef enum logic [3:0] {
      IDLE   = 4'b0001,
      RUN    = 4'b0010,
      FINISH = 4'b0100,
      OUTPUT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      in_ready   = 1'b0;
      out_valid  = 1'b0;
      unique case (state_ff)
         IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = RUN;
            end
         end
         RUN: begin
            cmd.step = 1'b1;
            if (stat.iter_done) state_in = FINISH;
         end
         FINISH: begin
            cmd.finish = 1'b1;
            state_in   = OUTPUT;
         end
         OUTPUT: begin
            out_valid = 1'b1;
            // result register frees as the next transaction comes in
            in_ready  = out_ready;
            if (out_ready) begin
               if (in_valid) begin
                  cmd.load = 1'b1;
                  state_in = RUN;
               end else begin
                  state_in = IDLE;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else       state_ff <= state_in;
   end

   a_no_out_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> !out_valid) else $error("output during run");
   a_finish_after_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == FINISH |-> $past(state_ff) == RUN) else $error("bad finish");
   a_output_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid) |-> $past(state_ff) == FINISH) else $error("bad output");

endmodule

@@ sv/q16_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q16 datapath
// Add/subtract, a multiply split into four 16x16 partial products, and a
// restoring division one quotient bit per cycle on magnitudes.
// ----------------------------------------------------------------------------
module q16_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  q16_pkg::q16_cmd_type                 cmd,
   output q16_pkg::q16_stat_type                stat,
   input  logic [q16_pkg::OpWidth-1:0]          req_type,
   input  logic signed [q16_pkg::DataWidth-1:0] operand_a,
   input  logic signed [q16_pkg::DataWidth-1:0] operand_b,
   output logic signed [q16_pkg::DataWidth-1:0] result_value,
   output logic [q16_pkg::StatWidth-1:0]        status
);

   localparam int unsigned W = q16_pkg::DataWidth;
   localparam int unsigned D = q16_pkg::DivBits;

   logic [q16_pkg::OpWidth-1:0]  op_ff;
   logic [W-1:0]                 a_ff, b_ff;
   logic [W-1:0]                 ma_ff, mb_ff;
   logic                         sa_ff, sb_ff;
   logic [q16_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic [D-1:0]                 num_ff, num_in;   // dividend shifting out / quotient in
   logic [W:0]                   rem_ff, rem_in;
   logic [63:0]                  prod_ff, prod_in;
   logic signed [W-1:0]          res_ff, res_in;
   logic [q16_pkg::StatWidth-1:0] st_ff, st_in;

   logic [W-1:0] ma_w, mb_w;
   logic [W+1:0] rem_sh, rem_sub;
   logic [15:0]  pa, pb;
   logic [31:0]  pp;

   assign ma_w = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
   assign mb_w = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;

   // multiply partial product chosen by step count
   always_comb begin
      pa = cnt_ff[0] ? ma_ff[31:16] : ma_ff[15:0];
      pb = cnt_ff[1] ? mb_ff[31:16] : mb_ff[15:0];
   end

   assign pp = pa * pb;

   assign rem_sh  = {rem_ff, num_ff[D-1]};
   assign rem_sub = rem_sh - {2'b00, mb_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      prod_in = prod_ff;
      if (cmd.load) begin
         cnt_in  = '0;
         // remainder divides |a| itself, divide divides |a| << 17
         num_in  = (req_type == q16_pkg::OpRem) ? {17'd0, ma_w} : {ma_w, 17'd0};
         rem_in  = '0;
         prod_in = '0;
      end else if (cmd.step) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == q16_pkg::OpDiv || op_ff == q16_pkg::OpRem) begin
            if (!rem_sub[W+1]) begin
               rem_in = rem_sub[W:0];
               num_in = {num_ff[D-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[W:0];
               num_in = {num_ff[D-2:0], 1'b0};
            end
         end else if (cnt_ff < 6'd4) begin
            prod_in = prod_ff + ({32'd0, pp} << {cnt_ff[1], 4'd0} << {cnt_ff[0], 4'd0});
         end
      end
   end

   assign stat.is_div    = (op_ff == q16_pkg::OpDiv) || (op_ff == q16_pkg::OpRem);
   assign stat.iter_done = stat.is_div ? (cnt_ff == 6'(D - 1)) : (cnt_ff == 6'd3);

   // result forming
   logic signed [W:0]  sum;
   logic [63:0]        p_s, q_s;
   logic [W:0]         rnd;
   logic               neg;
   logic [W-1:0]       rmag;

   always_comb begin
      res_in = res_ff;
      st_in  = st_ff;
      sum    = '0;
      p_s    = '0;
      q_s    = '0;
      rnd    = '0;
      neg    = sa_ff ^ sb_ff;
      rmag   = '0;
      if (cmd.finish) begin
         res_in = '0;
         st_in  = q16_pkg::StOk;
         case (op_ff)
            q16_pkg::OpAdd, q16_pkg::OpSub: begin
               sum = (op_ff == q16_pkg::OpAdd) ?
                     ({a_ff[W-1], a_ff} + {b_ff[W-1], b_ff}) :
                     ({a_ff[W-1], a_ff} - {b_ff[W-1], b_ff});
               if (sum[W] != sum[W-1]) begin
                  res_in = q16_pkg::OvfCode;
                  st_in  = q16_pkg::StOvf;
               end else begin
                  res_in = sum[W-1:0];
               end
            end
            q16_pkg::OpMul: begin
               p_s = neg ? (~prod_ff + 1'b1) : prod_ff;
               if ((p_s[63:47] != 17'd0) && (p_s[63:47] != 17'h1FFFF)) begin
                  res_in = q16_pkg::OvfCode;
                  st_in  = q16_pkg::StOvf;
               end else begin
                  q_s = p_s + 64'h8000 - {63'd0, p_s[63]};
                  if ((q_s[63:47] != 17'd0) && (q_s[63:47] != 17'h1FFFF)) begin
                     res_in = q16_pkg::OvfCode;
                     st_in  = q16_pkg::StOvf;
                  end else begin
                     res_in = q_s[47:16];
                  end
               end
            end
            q16_pkg::OpDiv: begin
               if (mb_ff == '0) begin
                  res_in = q16_pkg::OvfCode;
                  st_in  = q16_pkg::StDiv0;
               end else if (num_ff[D-1:W] != '0) begin
                  res_in = q16_pkg::OvfCode;
                  st_in  = q16_pkg::StOvf;
               end else begin
                  rnd = ({1'b0, num_ff[W-1:0]} + 1'b1) >> 1;
                  if (rnd[W-1]) begin
                     res_in = q16_pkg::OvfCode;
                     st_in  = q16_pkg::StOvf;
                  end else begin
                     res_in = neg ? (~rnd[W-1:0] + 1'b1) : rnd[W-1:0];
                  end
               end
            end
            q16_pkg::OpRem: begin
               if (mb_ff == '0) begin
                  st_in = q16_pkg::StDiv0;
               end else begin
                  // remainder takes the sign of the dividend
                  rmag   = rem_ff[W-1:0];
                  res_in = sa_ff ? (~rmag + 1'b1) : rmag;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_type;
         a_ff  <= operand_a;
         b_ff  <= operand_b;
         ma_ff <= ma_w;
         mb_ff <= mb_w;
         sa_ff <= operand_a[W-1];
         sb_ff <= operand_b[W-1];
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      num_ff  <= num_in;
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= q16_pkg::StOk;
      else       st_ff <= st_in;
   end

   assign result_value = res_ff;
   assign status       = st_ff;

endmodule

@@ sv/q16_16_fixed_point_alu.sv @@
`timescale 1ns / 1ps
// sequence: every operation steps through run, then finish, then output;
// divide and remainder produce one quotient bit per cycle over 49 bits
// transactions: one at a time, the next accepted as the result leaves
// reset: synchronous active high, returns the controller to idle
// ----------------------------------------------------------------------------
// q16.16 fixed point alu
// Signed Q16.16 add, subtract, multiply, divide and remainder with status.
// ----------------------------------------------------------------------------
module q16_16_fixed_point_alu (
   input  logic       clock,
   input  logic       reset,
   q16_req_if.sink    req,
   q16_rsp_if.source  rsp
);

   q16_pkg::q16_cmd_type  cmd;
   q16_pkg::q16_stat_type stat;

   q16_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   q16_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_type     (req.req_type),
      .operand_a    (req.operand_a),
      .operand_b    (req.operand_b),
      .result_value (rsp.result_value),
      .status       (rsp.status)
   );

endmodule

@@ tb/sv/q16_16_fixed_point_alu_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q16.16 fixed point alu testbench
// A directed table of operands and opcodes, then random traffic with random
// idle bursts on both channels. Every result is checked against a predictor.
// ----------------------------------------------------------------------------
module q16_16_fixed_point_alu_tb;

   typedef struct packed {
      logic [q16_pkg::OpWidth-1:0]          op;
      logic signed [q16_pkg::DataWidth-1:0] a;
      logic signed [q16_pkg::DataWidth-1:0] b;
   } alu_op_type;

   typedef struct packed {
      logic [q16_pkg::DataWidth-1:0] value;
      logic [q16_pkg::StatWidth-1:0] st;
   } alu_res_type;

   typedef struct packed {
      alu_op_type                    cmd;
      logic                          known;
      logic [q16_pkg::DataWidth-1:0] value;
      logic [q16_pkg::StatWidth-1:0] st;
   } table_row_type;

   localparam int NumRandom  = 1200;
   localparam int CycleLimit = 1000000;

   // opcodes with no operation behind them
   localparam logic [q16_pkg::OpWidth-1:0] OpUnusedLo = 3'd5;
   localparam logic [q16_pkg::OpWidth-1:0] OpUnusedHi = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   q16_req_if req ();
   q16_rsp_if rsp ();

   q16_16_fixed_point_alu dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   alu_res_type pending_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_off    = 1'b0;
   bit          stim_done   = 1'b0;

   function automatic logic [63:0] abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic alu_res_type compute_alu(alu_op_type c);
      alu_res_type r;
      longint      a, b, s, p, q;
      logic [63:0] ma, mb, quo, rnd;
      a = c.a;
      b = c.b;
      r.value = '0;
      r.st    = q16_pkg::StOk;
      case (c.op)
         q16_pkg::OpAdd, q16_pkg::OpSub: begin
            s = (c.op == q16_pkg::OpAdd) ? a + b : a - b;
            if (s < -64'sd2147483648 || s > 64'sd2147483647) begin
               r.value = q16_pkg::OvfCode; r.st = q16_pkg::StOvf;
            end else r.value = s[31:0];
         end
         q16_pkg::OpMul: begin
            p = a * b;
            if (p < -(64'sd1 <<< 47) || p >= (64'sd1 <<< 47)) begin
               r.value = q16_pkg::OvfCode; r.st = q16_pkg::StOvf;
            end else begin
               q = p + 64'sd32768 - ((p < 0) ? 64'sd1 : 64'sd0);
               q = q >>> 16;
               if (q < -64'sd2147483648 || q > 64'sd2147483647) begin
                  r.value = q16_pkg::OvfCode; r.st = q16_pkg::StOvf;
               end else r.value = q[31:0];
            end
         end
         q16_pkg::OpDiv: begin
            if (b == 0) begin
               r.value = q16_pkg::OvfCode; r.st = q16_pkg::StDiv0;
            end else begin
               ma = abs64(a); mb = abs64(b);
               quo = (ma << 17) / mb;
               rnd = (quo + 64'd1) >> 1;
               if (quo > 64'hFFFF_FFFF || rnd > 64'h7FFF_FFFF) begin
                  r.value = q16_pkg::OvfCode; r.st = q16_pkg::StOvf;
               end else begin
                  if ((a < 0) != (b < 0)) rnd = -rnd;
                  r.value = rnd[31:0];
               end
            end
         end
         q16_pkg::OpRem: begin
            if (b == 0) r.st = q16_pkg::StDiv0;
            else begin
               rnd = abs64(a) % abs64(b);
               if (a < 0) rnd = -rnd;
               r.value = rnd[31:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // directed table: known rows carry the obvious answer
   localparam int NumRows = 24;
   table_row_type rows [NumRows] = '{
      '{'{q16_pkg::OpAdd, 32'h7FFF_FFFF, 32'h1}, 1'b1, q16_pkg::OvfCode, q16_pkg::StOvf},
      '{'{q16_pkg::OpAdd, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b1, q16_pkg::OvfCode,
        q16_pkg::StOvf},
      '{'{q16_pkg::OpAdd, 32'h8000_0000, 32'h0}, 1'b1, 32'h8000_0000, q16_pkg::StOk},
      '{'{q16_pkg::OpAdd, 32'h0001_0000, 32'h0001_0000}, 1'b1, 32'h0002_0000, q16_pkg::StOk},
      '{'{q16_pkg::OpSub, 32'h8000_0000, 32'h1}, 1'b1, q16_pkg::OvfCode, q16_pkg::StOvf},
      '{'{q16_pkg::OpSub, 32'h0, 32'h8000_0000}, 1'b1, q16_pkg::OvfCode, q16_pkg::StOvf},
      '{'{q16_pkg::OpSub, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1, 32'h0, q16_pkg::StOk},
      '{'{q16_pkg::OpMul, 32'h0001_0000, 32'h0003_0000}, 1'b1, 32'h0003_0000, q16_pkg::StOk},
      '{'{q16_pkg::OpMul, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1, q16_pkg::OvfCode,
        q16_pkg::StOvf},
      '{'{q16_pkg::OpMul, 32'h8000_0000, 32'h0001_0000}, 1'b1, 32'h8000_0000, q16_pkg::StOk},
      '{'{q16_pkg::OpMul, 32'h7FFF_FFFF, 32'h0001_0000}, 1'b0, 32'h0, q16_pkg::StOk},
      '{'{q16_pkg::OpMul, 32'h0000_8000, 32'h0000_0001}, 1'b0, 32'h0, q16_pkg::StOk},
      '{'{q16_pkg::OpMul, 32'hFFFF_8000, 32'h0000_0001}, 1'b0, 32'h0, q16_pkg::StOk},
      '{'{q16_pkg::OpMul, 32'h7FFF_FFFF, 32'h0001_0001}, 1'b0, 32'h0, q16_pkg::StOk},
      '{'{q16_pkg::OpDiv, 32'h0001_0000, 32'h0}, 1'b1, q16_pkg::OvfCode, q16_pkg::StDiv0},
      '{'{q16_pkg::OpDiv, 32'h7FFF_FFFF, 32'h1}, 1'b1, q16_pkg::OvfCode, q16_pkg::StOvf},
      '{'{q16_pkg::OpDiv, 32'h8000_0000, 32'h0001_0000}, 1'b1, q16_pkg::OvfCode,
        q16_pkg::StOvf},
      '{'{q16_pkg::OpDiv, 32'h4000_0000, 32'hFFFF_8000}, 1'b1, q16_pkg::OvfCode,
        q16_pkg::StOvf},
      '{'{q16_pkg::OpDiv, 32'h0003_0000, 32'hFFFE_0000}, 1'b0, 32'h0, q16_pkg::StOk},
      '{'{q16_pkg::OpRem, 32'h0005_0000, 32'h0}, 1'b1, 32'h0, q16_pkg::StDiv0},
      '{'{q16_pkg::OpRem, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b1, 32'h0, q16_pkg::StOk},
      '{'{q16_pkg::OpRem, 32'hFFF9_0000, 32'h0002_0000}, 1'b0, 32'h0, q16_pkg::StOk},
      '{'{OpUnusedLo, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 32'h0, q16_pkg::StOk},
      '{'{OpUnusedHi, 32'h1234_5678, 32'h8765_4321}, 1'b1, 32'h0, q16_pkg::StOk}
   };

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000 | $urandom_range(0, 3);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 3) - 2;
         3: return $urandom & 32'h000F_FFFF;
         4: return $signed($urandom & 32'h0003_FFFF) - 32'sh0002_0000;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the accept
   task automatic send_op(alu_op_type c);
      int gap;
      if (!idle_off && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid     <= 1'b1;
      req.req_type  <= c.op;
      req.operand_a <= c.a;
      req.operand_b <= c.b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_results.push_back(compute_alu(c));
      @(negedge clock);
   endtask

   // response side: random stall bursts, check at the accepting edge
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (idle_off) rsp.ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready  <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp.ready  <= 1'b0;
      end else rsp.ready <= 1'b1;
   end

   always @(posedge clock) begin
      alu_res_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction value %h status %0d", $time,
                     rsp.result_value, rsp.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp.result_value !== want.value) begin
               $display("%0t: result_value expected %h actual %h", $time,
                        want.value, rsp.result_value);
               error_count++;
            end
            if (rsp.status !== want.st) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.st, rsp.status);
               error_count++;
            end
         end
      end
   end

   initial begin
      alu_op_type  c;
      alu_res_type got;
      req.valid     = 1'b0;
      req.req_type  = '0;
      req.operand_a = '0;
      req.operand_b = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NumRows; i++) begin
         if (rows[i].known) begin
            got = compute_alu(rows[i].cmd);
            if (got.value !== rows[i].value || got.st !== rows[i].st) begin
               $display("%0t: table row %0d expected %h/%0d actual %h/%0d", $time, i,
                        rows[i].value, rows[i].st, got.value, got.st);
               error_count++;
            end
         end
         send_op(rows[i].cmd);
      end
      for (int i = 0; i < NumRandom; i++) begin
         if (i == NumRandom / 2) begin
            req.valid <= 1'b0;
            @(negedge clock);
            while (pending_results.size() != 0) @(negedge clock);
         end
         if (i == NumRandom - 150) idle_off = 1'b1;
         c.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) :
                3'($urandom_range(0, 4));
         c.a  = pick_operand();
         c.b  = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand();
         send_op(c);
      end
      req.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
